// ----- src/jnc_pkg.sv -----
// Package for the JVM numeric conversion block: conversion codes and constants.
// Used by jvm_numeric_conversion; depends on nothing.
package jnc_pkg;

    typedef enum logic [3:0] {
        OP_I2L = 4'd0, OP_I2F = 4'd1, OP_I2D = 4'd2, OP_L2I = 4'd3,
        OP_L2F = 4'd4, OP_L2D = 4'd5, OP_F2I = 4'd6, OP_F2L = 4'd7,
        OP_F2D = 4'd8, OP_D2I = 4'd9, OP_D2L = 4'd10, OP_D2F = 4'd11,
        OP_I2B = 4'd12, OP_I2C = 4'd13, OP_I2S = 4'd14
    } op_t;

    localparam logic [63:0] SAT32_POS = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] SAT32_NEG = 64'h0000_0000_8000_0000;
    localparam logic [63:0] SAT64_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SAT64_NEG = 64'h8000_0000_0000_0000;

endpackage

// ----- src/jvm_numeric_conversion.sv -----
// JVM numeric conversion unit: converts among int, long, float and double.
// Depends on jnc_pkg.
//
// Usage: the slave channel carries one conversion per beat, s_tdata holding
// the opcode and the 64-bit operand. The master channel returns one beat per
// conversion: m_tdata holds the result bits and the wide flag.
// Each beat is latched in an input register, converted by combinational logic
// and written to the result register once that register is free, so a result
// is presented after its beat has passed both registers. One beat is taken per cycle
// while the receiver keeps up; the input register and the result register
// each hold one beat, and the input side stalls only when both are full and
// the receiver holds m_tready low. A stalled result stays unchanged.
// Reset clears both valid flags; no payload is reset.
module jvm_numeric_conversion
    import jnc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,   // [3:0] mode, [67:4] operand_bits, zero fill
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata    // [63:0] result_bits, [64] result_is_wide, zero fill
);

    logic        in_vld_reg;
    logic [3:0]  mode_reg;
    logic [63:0] op_reg;
    logic        out_vld_reg;
    logic [63:0] res_reg;
    logic        wide_reg;
    logic        adv;
    logic [63:0] res_next;
    logic        wide_next;

    assign adv      = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_vld_reg <= s_tvalid;
            end
            if (adv) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
        if (s_tready && s_tvalid) begin
            mode_reg <= s_tdata[3:0];
            op_reg   <= s_tdata[67:4];
        end
        if (adv) begin
            res_reg  <= res_next;
            wide_reg <= wide_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {7'd0, wide_reg, res_reg};

    // Integer source: sign and magnitude.
    logic        int_src, src_neg;
    logic [63:0] i64, mag;
    logic [5:0]  msb;
    logic [63:0] norm;

    assign i64 = {{32{op_reg[31]}}, op_reg[31:0]};

    always_comb begin
        int_src = (mode_reg == OP_I2F) || (mode_reg == OP_I2D);
        src_neg = int_src ? op_reg[31] : op_reg[63];
        mag     = int_src ? (op_reg[31] ? 64'd0 - i64 : i64)
                          : (op_reg[63] ? 64'd0 - op_reg : op_reg);
        msb = 6'd0;
        for (int k = 0; k < 64; k++) begin
            if (mag[k]) msb = 6'(k);
        end
        norm = mag << (6'd63 - msb);
    end

    // Rounded integer to float (24-bit) and double (53-bit).
    logic [31:0] itof;
    logic [63:0] itod;
    logic        gf, sf, gd, sd;
    logic [24:0] kf;
    logic [53:0] kd;

    always_comb begin
        gf = norm[39];
        sf = |norm[38:0];
        kf = {1'b0, norm[63:40]} + 25'(gf && (sf || norm[40]));
        gd = norm[10];
        sd = |norm[9:0];
        kd = {1'b0, norm[63:11]} + 54'(gd && (sd || norm[11]));
        if (mag == 64'd0) begin
            itof = 32'd0;
            itod = 64'd0;
        end else begin
            itof = {src_neg, 31'(({23'd0, msb} + 32'd126) << 23) + 31'(kf)};
            itod = {src_neg, 63'(({54'd0, msb} + 64'd1022) << 52) + 63'(kd)};
        end
    end

    // Float or double source fields.
    logic        fsrc, fs;
    logic [10:0] fex;
    logic [52:0] fsig;
    logic        fnan, finf, fzero;
    logic signed [12:0] fe;
    logic [63:0] tmag;
    logic [63:0] f2i32, f2i64;

    always_comb begin
        fsrc = (mode_reg == OP_F2I) || (mode_reg == OP_F2L);
        if (fsrc) begin
            fs    = op_reg[31];
            fnan  = (op_reg[30:23] == 8'hFF) && (op_reg[22:0] != 23'd0);
            finf  = (op_reg[30:23] == 8'hFF);
            fzero = (op_reg[30:23] == 8'd0);
            fe    = 13'(signed'({5'd0, op_reg[30:23]})) - 13'sd127;
            fsig  = {1'b1, op_reg[22:0], 29'd0};
        end else begin
            fs    = op_reg[63];
            fnan  = (op_reg[62:52] == 11'h7FF) && (op_reg[51:0] != 52'd0);
            finf  = (op_reg[62:52] == 11'h7FF);
            fzero = (op_reg[62:52] == 11'd0);
            fe    = 13'(signed'({2'd0, op_reg[62:52]})) - 13'sd1023;
            fsig  = {1'b1, op_reg[51:0]};
        end
        if (fe < 0 || fe > 13'sd63) tmag = 64'd0;
        else if (fe <= 13'sd52) tmag = {11'd0, fsig} >> 6'(13'sd52 - fe);
        else tmag = {11'd0, fsig} << 6'(fe - 13'sd52);
        if (fnan || fzero || fe < 0) f2i32 = 64'd0;
        else if (finf || fe >= 13'sd31) f2i32 = fs ? SAT32_NEG : SAT32_POS;
        else f2i32 = {32'd0, (fs ? 32'd0 - tmag[31:0] : tmag[31:0])};
        if (fnan || fzero || fe < 0) f2i64 = 64'd0;
        else if (finf || fe >= 13'sd63) f2i64 = fs ? SAT64_NEG : SAT64_POS;
        else f2i64 = fs ? 64'd0 - tmag : tmag;
    end

    // Float to double.
    logic [63:0] f2d;
    logic [22:0] sfr;
    logic [4:0]  smsb;
    always_comb begin
        smsb = 5'd0;
        for (int k = 0; k < 23; k++) begin
            if (op_reg[k]) smsb = 5'(k);
        end
        sfr = 23'(op_reg[22:0] << (5'd23 - smsb));
        if (op_reg[30:23] == 8'hFF) begin
            f2d = (op_reg[22:0] != 23'd0)
                ? {op_reg[31], 11'h7FF, 1'b1, op_reg[21:0], 29'd0}
                : {op_reg[31], 11'h7FF, 52'd0};
        end else if (op_reg[30:23] == 8'd0) begin
            f2d = (op_reg[22:0] == 23'd0) ? {op_reg[31], 63'd0}
                : {op_reg[31], 11'(11'd874 + {6'd0, smsb}), sfr, 29'd0};
        end else begin
            f2d = {op_reg[31], 11'({3'd0, op_reg[30:23]} + 11'd896),
                   op_reg[22:0], 29'd0};
        end
    end

    // Double to float.
    logic [31:0] d2f;
    logic signed [12:0] de;
    logic [10:0] dsh;
    logic [52:0] dsig, dkeep, drem, dhalf, dmask;
    logic [30:0] dbase, dbits;
    logic        dup;
    always_comb begin
        dmask = 53'd0;
        drem  = 53'd0;
        dhalf = 53'd0;
        de   = 13'(signed'({2'd0, op_reg[62:52]})) - 13'sd1023;
        dsig = {1'b1, op_reg[51:0]};
        if (de >= -13'sd126) begin
            dbase = 31'(de + 13'sd126);
            dsh   = 11'd29;
        end else begin
            dbase = 31'd0;
            dsh   = 11'(-13'sd97 - de);
        end
        if (dsh >= 11'd54) begin
            dkeep = 53'd0;
            dup   = 1'b0;
        end else begin
            dmask = (53'd1 << dsh[5:0]) - 53'd1;
            dkeep = dsig >> dsh[5:0];
            drem  = dsig & dmask;
            dhalf = 53'd1 << (dsh[5:0] - 6'd1);
            dup   = (drem > dhalf) || (drem == dhalf && dkeep[0]);
        end
        dbits = (dbase << 23) + 31'(dkeep) + 31'(dup);
        if (dbits >= 31'h7F80_0000) dbits = 31'h7F80_0000;
        if (op_reg[62:52] == 11'h7FF) begin
            d2f = (op_reg[51:0] != 52'd0)
                ? ({op_reg[63], 31'h7FC0_0000} | {9'd0, op_reg[51:29]})
                : {op_reg[63], 31'h7F80_0000};
        end else if (op_reg[62:52] == 11'd0) begin
            d2f = {op_reg[63], 31'd0};
        end else if (de > 13'sd127) begin
            d2f = {op_reg[63], 31'h7F80_0000};
        end else begin
            d2f = {op_reg[63], dbits};
        end
    end

    always_comb begin
        res_next  = 64'd0;
        wide_next = 1'b0;
        case (mode_reg)
            OP_I2L: begin res_next = i64; wide_next = 1'b1; end
            OP_I2F, OP_L2F: res_next = {32'd0, itof};
            OP_I2D, OP_L2D: begin res_next = itod; wide_next = 1'b1; end
            OP_L2I: res_next = {32'd0, op_reg[31:0]};
            OP_F2I, OP_D2I: res_next = f2i32;
            OP_F2L, OP_D2L: begin res_next = f2i64; wide_next = 1'b1; end
            OP_F2D: begin res_next = f2d; wide_next = 1'b1; end
            OP_D2F: res_next = {32'd0, d2f};
            OP_I2B: res_next = {32'd0, {24{op_reg[7]}}, op_reg[7:0]};
            OP_I2C: res_next = {48'd0, op_reg[15:0]};
            OP_I2S: res_next = {32'd0, {16{op_reg[15]}}, op_reg[15:0]};
            default: begin res_next = 64'd0; wide_next = 1'b0; end
        endcase
    end

endmodule
